[design/wfc_pkg.sv]
// shared types and constants for the windowed fir convolution unit
// no dependencies; imported by every module of the block
package wfc_pkg;

  // sizing of the filter and the arithmetic
  localparam int MAX_TAPS  = 64;
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int ACC_W     = 38;
  localparam int IDX_W     = 6;
  localparam int TAP_CNT_W = 7;
  localparam int WIN_W     = 16;
  localparam int SIDX_W    = 17;
  localparam int N_W       = $clog2(MAX_TAPS + 1);
  localparam int CNT_W     = (N_W > TAP_CNT_W) ? N_W : TAP_CNT_W;
  localparam int POS_W     = SIDX_W + 1;

  // stream and register port sizing
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // register map
  localparam logic [PADDR_W-1:0] REG_TAP_COUNT    = 4'h0;
  localparam logic [PADDR_W-1:0] REG_FIRST_OUTPUT = 4'h4;
  localparam logic [PADDR_W-1:0] REG_OUTPUT_COUNT = 4'h8;

  // register reset values
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST    = 7'd64;
  localparam logic [WIN_W-1:0]     FIRST_OUTPUT_RST = 16'd0;
  localparam logic [WIN_W-1:0]     OUTPUT_COUNT_RST = 16'd256;

  // input beat commands
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_PUSH = 1'b1
  } cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } state_e;

  // controls broadcast to the cell row
  typedef struct packed {
    logic shift;
    logic clear;
    logic start;
  } cell_ctl_t;

endpackage

[design/wfc_cell.sv]
// one filter cell: holds a tap and a history sample, adds its product,
// when its tap is enabled, to the partial sum passing by; depends on wfc_pkg
module wfc_cell import wfc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctl_t                  ctl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       tap_we_i,
  input  logic signed [SAMPLE_W-1:0] tap_i,
  input  logic                       tap_en_i,
  input  logic                       go_i,
  input  logic signed [ACC_W-1:0]    psum_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       go_o,
  output logic signed [ACC_W-1:0]    psum_o
);

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] tap_q;
  logic                       go_q;
  logic signed [ACC_W-1:0]    psum_q;
  logic signed [ACC_W-1:0]    psum_d;
  logic signed [PROD_W-1:0]   prod;

  // history and tap storage, sweep token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      tap_q    <= '0;
      go_q     <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        sample_q <= '0;
      end else if (ctl_i.shift) begin
        sample_q <= sample_i;
      end
      if (tap_we_i) begin
        tap_q <= tap_i;
      end
      go_q <= go_i;
    end
  end

  // multiply-accumulate on the passing partial sum
  assign prod   = PROD_W'(sample_q) * PROD_W'(tap_q);
  assign psum_d = tap_en_i ? psum_i + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} : psum_i;

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      psum_q <= psum_d;
    end
  end

  assign sample_o = sample_q;
  assign go_o     = go_q;
  assign psum_o   = psum_q;

endmodule

[design/wfc_ctrl.sv]
// sequencer, output window and result register of the convolution unit
// depends on wfc_pkg
module wfc_ctrl import wfc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  input  cmd_e                    cmd_i,
  input  logic                    eot_i,
  output logic                    s_ready_o,
  input  logic [CNT_W-1:0]        n_eff_i,
  input  logic [WIN_W-1:0]        first_output_i,
  input  logic [WIN_W-1:0]        output_count_i,
  input  logic                    go_done_i,
  input  logic signed [ACC_W-1:0] sum_i,
  output cell_ctl_t               cell_ctl_o,
  output logic                    m_valid_o,
  input  logic                    m_ready_i,
  output logic [ACC_W-1:0]        m_result_o,
  output logic                    m_last_o
);

  state_e             state_q, state_d;
  logic [SIDX_W-1:0]  sidx_q, sidx_d;
  logic               start_q;
  logic               emit_q, last_q, eot_q;
  logic               out_valid_q;
  logic [ACC_W-1:0]   out_result_q;
  logic               out_last_q;

  logic               push_acc;
  logic               finish;
  logic               done_item;
  logic               load_out;
  logic [CNT_W:0]     n_plus;
  logic [WIN_W-1:0]   first_def;
  logic [WIN_W-1:0]   first_eff;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   first_ext;
  logic [POS_W-1:0]   win_end;
  logic               in_win;
  logic               is_last;

  assign s_ready_o = (state_q == ST_IDLE);
  assign push_acc  = s_valid_i && s_ready_o && (cmd_i == CMD_PUSH);

  // window bounds for the sample being pushed
  assign n_plus    = {1'b0, n_eff_i} + {{CNT_W{1'b0}}, 1'b1};
  assign first_def = (n_plus[CNT_W:1] == '0) ? WIN_W'(1) : WIN_W'(n_plus[CNT_W:1]);
  assign first_eff = (first_output_i != '0) ? first_output_i : first_def;
  assign pos       = {1'b0, sidx_q} + POS_W'(1);
  assign first_ext = POS_W'(first_eff);
  assign win_end   = POS_W'(first_eff) + POS_W'(output_count_i);
  assign in_win    = (output_count_i != '0) && (pos >= first_ext) && (pos < win_end);
  assign is_last   = (pos == win_end - POS_W'(1));

  // saturating sample counter, cleared by end of trace
  always_comb begin
    sidx_d = sidx_q;
    if (push_acc) begin
      if (eot_i) begin
        sidx_d = '0;
      end else if (sidx_q != {SIDX_W{1'b1}}) begin
        sidx_d = sidx_q + SIDX_W'(1);
      end
    end
  end

  // item hand-off when the sweep has left the last cell
  assign finish    = ((state_q == ST_SWEEP) && go_done_i) || (state_q == ST_HOLD);
  assign done_item = finish && (!emit_q || !out_valid_q || m_ready_i);
  assign load_out  = done_item && emit_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (push_acc) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (go_done_i) state_d = done_item ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (done_item) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // cell row controls
  always_comb begin
    cell_ctl_o.shift = push_acc;
    cell_ctl_o.clear = done_item && eot_q;
    cell_ctl_o.start = start_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sidx_q      <= '0;
      start_q     <= 1'b0;
      emit_q      <= 1'b0;
      last_q      <= 1'b0;
      eot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sidx_q  <= sidx_d;
      start_q <= push_acc;
      if (push_acc) begin
        emit_q <= in_win;
        last_q <= is_last;
        eot_q  <= eot_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_result_q <= sum_i;
      out_last_q   <= last_q;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_result_q;
  assign m_last_o   = out_last_q;

`ifndef SYNTH
  // the sweep token leaves the row only while a sweep runs
  a_done_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_done_i |-> state_q == ST_SWEEP)
    else $error("sweep token left the row outside a sweep");

  // the token enters the row right after a push
  a_start_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctl_o.start |-> state_q == ST_SWEEP)
    else $error("sweep started outside a sweep");

  // history is never shifted and cleared together
  a_clear_no_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctl_o.clear |-> !cell_ctl_o.shift)
    else $error("history clear during shift");

  // holding only happens for a result blocked by a full output register
  a_hold_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> emit_q && out_valid_q)
    else $error("hold without a blocked result");
`endif

endmodule

[design/windowed_fir_convolution_unit.sv]
// top level of the windowed fir convolution unit: register port, input
// decode and the row of filter cells; depends on wfc_pkg, wfc_cell, wfc_ctrl
//
//  port group   dir  beat contents
//  s_axis_*     in   tap load or reference sample, tlast = end of trace
//  m_axis_*     out  windowed convolution result, tlast = last of window
//  p*           in   register writes and reads (tap_count, first_output,
//                    output_count)
//
// a tap load leaves the input ready; a sample push runs in steps: the
// accept, the partial sum running the row cell by cell, and the hand-off
// to the result register. the push path is busy until then.
// reset clears taps, history and the sample counter, and sets the registers to their reset values.
// a result blocked on m_axis waits in the result register; a second one
// holds the row until the first is taken.
module windowed_fir_convolution_unit import wfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // command, tap_index, value, zero pad
  input  logic                 s_axis_tlast,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // result, zero pad
  output logic                 m_axis_tlast,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  logic [TAP_CNT_W-1:0]       tap_count_q;
  logic [WIN_W-1:0]           first_output_q;
  logic [WIN_W-1:0]           output_count_q;
  logic [CNT_W-1:0]           n_eff;

  cmd_e                       in_cmd;
  logic [IDX_W-1:0]           in_tap_index;
  logic signed [SAMPLE_W-1:0] in_value;
  logic                       load_acc;

  cell_ctl_t                  cell_ctl;
  logic signed [SAMPLE_W-1:0] hist_w [MAX_TAPS];
  logic                       go_w   [MAX_TAPS];
  logic signed [ACC_W-1:0]    psum_w [MAX_TAPS];
  logic [ACC_W-1:0]           m_result;

  // input beat fields
  assign in_cmd       = cmd_e'(s_axis_tdata[0]);
  assign in_tap_index = s_axis_tdata[IDX_W:1];
  assign in_value     = s_axis_tdata[IDX_W+SAMPLE_W:IDX_W+1];
  assign load_acc     = s_axis_tvalid && s_axis_tready && (in_cmd == CMD_LOAD);

  // register writes
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q    <= TAP_COUNT_RST;
      first_output_q <= FIRST_OUTPUT_RST;
      output_count_q <= OUTPUT_COUNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr)
        REG_TAP_COUNT:    tap_count_q    <= pwdata[TAP_CNT_W-1:0];
        REG_FIRST_OUTPUT: first_output_q <= pwdata[WIN_W-1:0];
        REG_OUTPUT_COUNT: output_count_q <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr)
      REG_TAP_COUNT:    prdata = PDATA_W'(tap_count_q);
      REG_FIRST_OUTPUT: prdata = PDATA_W'(first_output_q);
      REG_OUTPUT_COUNT: prdata = PDATA_W'(output_count_q);
      default:          prdata = '0;
    endcase
  end

  // tap count limited to the row length
  assign n_eff = (CNT_W'(tap_count_q) > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                          : CNT_W'(tap_count_q);

  // row of cells: history shifts right, partial sum sweeps right
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       go_in;
    logic signed [ACC_W-1:0]    psum_in;

    if (k == 0) begin : g_head
      assign sample_in = in_value;
      assign go_in     = cell_ctl.start;
      assign psum_in   = '0;
    end else begin : g_body
      assign sample_in = hist_w[k-1];
      assign go_in     = go_w[k-1];
      assign psum_in   = psum_w[k-1];
    end

    wfc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (cell_ctl),
      .sample_i (sample_in),
      .tap_we_i (load_acc && (int'(in_tap_index) == k)),
      .tap_i    (in_value),
      .tap_en_i (n_eff > CNT_W'(k)),
      .go_i     (go_in),
      .psum_i   (psum_in),
      .sample_o (hist_w[k]),
      .go_o     (go_w[k]),
      .psum_o   (psum_w[k])
    );
  end

  // sequencer and result register
  wfc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid),
    .cmd_i          (in_cmd),
    .eot_i          (s_axis_tlast),
    .s_ready_o      (s_axis_tready),
    .n_eff_i        (n_eff),
    .first_output_i (first_output_q),
    .output_count_i (output_count_q),
    .go_done_i      (go_w[MAX_TAPS-1]),
    .sum_i          (psum_w[MAX_TAPS-1]),
    .cell_ctl_o     (cell_ctl),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_result_o     (m_result),
    .m_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {{(M_TDATA_W-ACC_W){1'b0}}, m_result};

endmodule

[tb/wfc_result_checker.sv]
// result checker for the windowed fir convolution unit: watches both streams and
// the register port, predicts every windowed result and compares it beat by beat
// depends on wfc_pkg
module wfc_result_checker import wfc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream, observed
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [S_TDATA_W-1:0] s_data_i,   // command, tap_index, value, zero pad
  input  logic                 s_last_i,
  // result stream, observed
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [M_TDATA_W-1:0] m_data_i,   // result, zero pad
  input  logic                 m_last_i,
  // register port, observed
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [PADDR_W-1:0]   paddr_i,
  input  logic [PDATA_W-1:0]   pwdata_i,
  input  logic [PDATA_W-1:0]   prdata_i,
  input  logic                 pready_i,
  // status toward the stimulus side
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   result_count_o,
  output int                   push_count_o,
  output int                   load_count_o,
  output int                   setting_count_o
);

  typedef struct packed {
    logic [ACC_W-1:0] result;
    logic             last;
  } win_result_t;

  // expected windowed results, oldest first
  win_result_t window_results_q [$];

  // filter state mirror
  logic signed [SAMPLE_W-1:0] tap_mem    [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] trace_hist [MAX_TAPS];
  logic [SIDX_W-1:0]          sample_idx;
  logic [TAP_CNT_W-1:0]       tap_count_r;
  logic [WIN_W-1:0]           first_output_r;
  logic [WIN_W-1:0]           output_count_r;

  int fails, results, pushes, loads, settings;

  assign fail_count_o    = fails;
  assign result_count_o  = results;
  assign push_count_o    = pushes;
  assign load_count_o    = loads;
  assign setting_count_o = settings;

  // shift one sample into the history, form the full convolution value and
  // decide whether its index falls inside the output window
  function automatic bit convolve_sample(input logic signed [SAMPLE_W-1:0] sample,
                                         input logic eot, output win_result_t res);
    longint      acc;
    int unsigned n;
    int unsigned first;
    int unsigned pos;
    bit          emit;
    for (int k = MAX_TAPS - 1; k > 0; k--) trace_hist[k] = trace_hist[k-1];
    trace_hist[0] = sample;
    n = (tap_count_r > MAX_TAPS) ? MAX_TAPS : tap_count_r;
    acc = 0;
    for (int k = 0; k < n; k++) acc += longint'(trace_hist[k]) * longint'(tap_mem[k]);
    // zero selects the centered default, never below one
    first = first_output_r;
    if (first == 0) begin
      first = (n + 1) / 2;
      if (first == 0) first = 1;
    end
    pos = sample_idx + 1;
    emit = (output_count_r != 0) && (pos >= first) && (pos < first + output_count_r);
    res.result = acc[ACC_W-1:0];
    res.last = (pos == first + output_count_r - 1);
    // counter holds at its top value
    if (sample_idx != '1) sample_idx++;
    if (eot) begin
      foreach (trace_hist[k]) trace_hist[k] = '0;
      sample_idx = '0;
    end
    return emit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    win_result_t                want;
    win_result_t                got;
    logic [PDATA_W-1:0]         reg_val;
    cmd_e                       cmd;
    logic [IDX_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] val;
    int                         added;
    int                         taken;
    if (!rst_ni) begin
      foreach (tap_mem[k]) tap_mem[k] = '0;
      foreach (trace_hist[k]) trace_hist[k] = '0;
      sample_idx     = '0;
      tap_count_r    = TAP_COUNT_RST;
      first_output_r = FIRST_OUTPUT_RST;
      output_count_r = OUTPUT_COUNT_RST;
      window_results_q.delete();
      fails = 0; results = 0; pushes = 0; loads = 0; settings = 0;
      pending_o <= 0;
    end else begin
      added = 0;
      taken = 0;
      // register port: writes update the mirror, reads are compared with it
      if (psel_i && penable_i && pready_i) begin
        case (paddr_i)
          REG_TAP_COUNT:    reg_val = PDATA_W'(tap_count_r);
          REG_FIRST_OUTPUT: reg_val = PDATA_W'(first_output_r);
          REG_OUTPUT_COUNT: reg_val = PDATA_W'(output_count_r);
          default:          reg_val = '0;
        endcase
        if (pwrite_i) begin
          settings++;
          case (paddr_i)
            REG_TAP_COUNT:    tap_count_r    = pwdata_i[TAP_CNT_W-1:0];
            REG_FIRST_OUTPUT: first_output_r = pwdata_i[WIN_W-1:0];
            REG_OUTPUT_COUNT: output_count_r = pwdata_i[WIN_W-1:0];
            default: ;
          endcase
        end else if (prdata_i !== reg_val) begin
          $error("prdata at %0h: expected %0h actual %0h", paddr_i, reg_val, prdata_i);
          fails++;
        end
      end
      // input beat: tap load or sample push
      if (s_valid_i && s_ready_i) begin
        cmd = cmd_e'(s_data_i[0]);
        idx = s_data_i[IDX_W:1];
        val = s_data_i[IDX_W+SAMPLE_W:IDX_W+1];
        if (cmd == CMD_LOAD) begin
          tap_mem[idx] = val;
          loads++;
        end else begin
          pushes++;
          if (convolve_sample(val, s_last_i, want)) begin
            window_results_q.insert(window_results_q.size(), want);
            added = 1;
          end
        end
      end
      // result beat against the oldest expectation
      if (m_valid_i && m_ready_i) begin
        results++;
        got.result = m_data_i[ACC_W-1:0];
        got.last   = m_last_i;
        if (window_results_q.size() == 0) begin
          $error("result beat with nothing expected: result %0h last %0b",
                 got.result, got.last);
          fails++;
        end else begin
          want = window_results_q.pop_front();
          taken = 1;
          if (got.result !== want.result) begin
            $error("result: expected %0h actual %0h", want.result, got.result);
            fails++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b actual %0b", want.last, got.last);
            fails++;
          end
        end
      end
      pending_o <= pending_o + added - taken;
    end
  end

endmodule

[tb/testbench.sv]
// top of the windowed fir convolution unit testbench: clock, reset, stream and
// register stimulus, verdict; depends on wfc_pkg, windowed_fir_convolution_unit
// and wfc_result_checker
module testbench;
  import wfc_pkg::*;

  localparam int ITEMS          = 1150;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RX_HOLD_CYCLES = 600;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // command, tap_index, value, zero pad
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // result, zero pad
  logic                 m_axis_tlast;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int fail_count, pending_cnt, result_count, push_count, load_count, setting_count;
  int beats_sent = 0;
  bit calm = 1'b0;          // both sides run without gaps
  bit rx_hold_req = 1'b0;   // asks the receiver for one long hold-off

  always #2 clk_i = ~clk_i;

  windowed_fir_convolution_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  wfc_result_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_last_i(s_axis_tlast),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_last_i(m_axis_tlast),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending_cnt),
    .result_count_o(result_count), .push_count_o(push_count),
    .load_count_o(load_count), .setting_count_o(setting_count)
  );

  // sample values leaning toward the extremes
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // one input beat, after a random gap when not calm
  task automatic send_beat(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] val, input logic eot);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, idx, cmd};
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic wait_drained(input int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // new register setting on an idle block, then read it back
  task automatic apply_setting(input int tc, input int fo, input int oc);
    wait_drained(DRAIN_CYCLES);
    reg_access(1'b1, REG_TAP_COUNT, PDATA_W'(tc));
    reg_access(1'b1, REG_FIRST_OUTPUT, PDATA_W'(fo));
    reg_access(1'b1, REG_OUTPUT_COUNT, PDATA_W'(oc));
    reg_access(1'b0, REG_TAP_COUNT, '0);
    reg_access(1'b0, REG_FIRST_OUTPUT, '0);
    reg_access(1'b0, REG_OUTPUT_COUNT, '0);
  endtask

  // random tap loads followed by traces with noise loads and early ends
  task automatic run_phase(input int load_n, input int trace_max, input int traces);
    int len;
    repeat (load_n)
      send_beat(CMD_LOAD, IDX_W'($urandom), rand_sample(), 1'($urandom));
    repeat (traces) begin
      len = $urandom_range(1, trace_max);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(CMD_LOAD, IDX_W'($urandom), rand_sample(), 1'($urandom));
        send_beat(CMD_PUSH, IDX_W'($urandom), rand_sample(),
                  (j == len - 1) || ($urandom_range(0, 29) == 0));
        if ($urandom_range(0, 39) == 0) wait_drained(0);
      end
    end
  endtask

  // full-scale taps and samples for the widest sums
  task automatic run_full_scale(input logic [SAMPLE_W-1:0] tap_val);
    for (int k = 0; k < MAX_TAPS; k++) send_beat(CMD_LOAD, IDX_W'(k), tap_val, 1'b0);
    for (int j = 0; j < MAX_TAPS + 4; j++)
      send_beat(CMD_PUSH, '0, SAMPLE_MIN, j == MAX_TAPS + 3);
  endtask

  // receiver: random stalls per beat, one long hold-off on request
  initial begin : receiver
    int gap;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 10);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        gap = RX_HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    int tc, fo, oc;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: four taps in use, two at the extremes, window from the first index
    apply_setting(4, 1, 6);
    send_beat(CMD_LOAD, 6'd0, SAMPLE_MAX, 1'b1);
    send_beat(CMD_LOAD, 6'd1, SAMPLE_MIN, 1'b0);
    send_beat(CMD_LOAD, 6'd2, 16'h0001, 1'b0);
    send_beat(CMD_LOAD, 6'd3, '1, 1'b0);
    send_beat(CMD_LOAD, 6'd63, SAMPLE_MIN, 1'b1);
    send_beat(CMD_PUSH, 6'd0, SAMPLE_MIN, 1'b0);
    send_beat(CMD_PUSH, 6'd63, SAMPLE_MAX, 1'b0);
    send_beat(CMD_PUSH, 6'd0, SAMPLE_MIN, 1'b0);
    send_beat(CMD_PUSH, 6'd0, '0, 1'b0);
    send_beat(CMD_PUSH, 6'd0, '1, 1'b0);
    send_beat(CMD_PUSH, 6'd0, 16'h0001, 1'b0);
    send_beat(CMD_PUSH, 6'd0, SAMPLE_MAX, 1'b1);
    send_beat(CMD_PUSH, 6'd0, SAMPLE_MAX, 1'b0);
    send_beat(CMD_PUSH, 6'd0, SAMPLE_MIN, 1'b0);
    send_beat(CMD_PUSH, 6'd0, '0, 1'b1);

    // zero taps in use: all sums zero, default window starts at one
    apply_setting(0, 0, 5);
    run_phase(3, 12, 3);
    // tap count above the filter length behaves as the full length
    apply_setting(127, 0, 3);
    run_phase(40, 40, 2);
    // empty window
    apply_setting(64, 1, 0);
    run_phase(4, 10, 2);
    // window far beyond any trace
    apply_setting(1, 65535, 65535);
    run_phase(4, 10, 2);
    // widest positive and negative sums
    apply_setting(64, 64, 4);
    run_full_scale(SAMPLE_MIN);
    run_full_scale(SAMPLE_MAX);
    // long receiver hold-off while the sender keeps offering
    apply_setting(8, 1, 20);
    rx_hold_req = 1'b1;
    run_phase(8, 30, 3);

    // random settings and traces
    while (beats_sent < ITEMS) begin
      case ($urandom_range(0, 5))
        0: tc = 1;
        1: tc = MAX_TAPS;
        2: tc = $urandom_range(MAX_TAPS + 1, 127);
        default: tc = $urandom_range(1, MAX_TAPS);
      endcase
      case ($urandom_range(0, 4))
        0, 1: fo = 0;
        2: fo = 1;
        default: fo = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 4))
        0: oc = 1;
        1: oc = 65535;
        default: oc = $urandom_range(1, 24);
      endcase
      apply_setting(tc, fo, oc);
      calm = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(0, 16), 48, 3);
      calm = 1'b0;
    end

    // drain, let the row settle, then report
    wait_drained(DRAIN_CYCLES);
    $display("covered %0d tap loads, %0d sample pushes and %0d checked results",
             load_count, push_count, result_count);
    $display("over %0d register writes, with full-scale sums and a long output stall",
             setting_count);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

[sim.f]
design/wfc_pkg.sv
design/wfc_cell.sv
design/wfc_ctrl.sv
design/windowed_fir_convolution_unit.sv
tb/wfc_result_checker.sv
tb/testbench.sv
